// ===== hdl/dcmc_pkg.sv =====
// ---------------------------------------------------------------------------
// Dual cover motor controller package
// Shared widths, codes and the control bundle passed to each motor channel.
// ---------------------------------------------------------------------------
package dcmc_pkg;

  // Field widths.
  localparam int KIND_W    = 2;
  localparam int KEYS_N    = 4;
  localparam int CMD_W     = 2;
  localparam int STATE_W   = 2;
  localparam int TICK_W    = 16;
  localparam int HOLD_W    = 8;
  localparam int LED_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_KEY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd2;

  // Motor states, which double as remote command codes.
  localparam logic [STATE_W-1:0] ST_STOP = 2'd0;
  localparam logic [STATE_W-1:0] ST_UP   = 2'd1;
  localparam logic [STATE_W-1:0] ST_DOWN = 2'd2;

  // The one remote command code that is ignored.
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_BRIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LED_DIM    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TICK_W-1:0] RUN_LIMIT_RST  = 16'd50;
  localparam logic [HOLD_W-1:0] PRESS_RST      = 8'd2;
  localparam logic [LED_W-1:0]  LED_BRIGHT_RST = 8'd128;
  localparam logic [LED_W-1:0]  LED_DIM_RST    = 8'd8;

  // Saturation value of a key hold counter.
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // Per-channel control for the item being processed.
  typedef struct packed {
    logic                fire;
    logic                is_key;
    logic                is_tick;
    logic                is_cmd;
    logic                up_hit;
    logic                dn_hit;
    logic                cmd_hit;
    logic [STATE_W-1:0]  cmd_state;
  } dcmc_ctl_t;

endpackage

// ===== hdl/dual_cover_motor_controller.sv =====
// ---------------------------------------------------------------------------
// Dual cover motor controller
// Key sampling, remote commands and output ticks for two cover motors.
// ---------------------------------------------------------------------------
// Pipeline: two register stages; an accepted item moves from the input register
// to the result register, and waits in the input register while results stall.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: synchronous, active low; both motors stop, open flags set, hold
// counters cleared and configuration registers back to their defaults.
module dual_cover_motor_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dcmc_pkg::KIND_W-1:0]      in_kind,
  input  logic [dcmc_pkg::KEYS_N-1:0]      in_key_levels,
  input  logic                             in_channel,
  input  logic [dcmc_pkg::CMD_W-1:0]       in_command,
  // Result item channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       out_relay_bits,
  output logic [dcmc_pkg::LED_W-1:0]       out_led_up_ch0,
  output logic [dcmc_pkg::LED_W-1:0]       out_led_up_ch1,
  output logic [dcmc_pkg::LED_W-1:0]       out_led_down_ch0,
  output logic [dcmc_pkg::LED_W-1:0]       out_led_down_ch1,
  output logic [1:0]                       out_open_flags,
  output logic                             out_state_changed,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [dcmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcmc_pkg::CFG_W-1:0]       cfg_wdata
);
  import dcmc_pkg::*;

  // Configuration registers.
  logic [TICK_W-1:0] run_limit_r;
  logic [HOLD_W-1:0] press_r;
  logic [LED_W-1:0]  led_bright_r;
  logic [LED_W-1:0]  led_dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r  <= RUN_LIMIT_RST;
      press_r      <= PRESS_RST;
      led_bright_r <= LED_BRIGHT_RST;
      led_dim_r    <= LED_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_LIMIT:  run_limit_r  <= cfg_wdata;
        REG_PRESS:      press_r      <= cfg_wdata[HOLD_W-1:0];
        REG_LED_BRIGHT: led_bright_r <= cfg_wdata[LED_W-1:0];
        REG_LED_DIM:    led_dim_r    <= cfg_wdata[LED_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic              s1_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [KEYS_N-1:0] levels_r;
  logic              chan_r;
  logic [CMD_W-1:0]  cmd_r;
  logic              advance;
  logic              fire;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r   <= in_kind;
      levels_r <= in_key_levels;
      chan_r   <= in_channel;
      cmd_r    <= in_command;
    end
  end

  // Key hold counters and press detection.
  logic [HOLD_W-1:0] key_hold_r   [KEYS_N];
  logic [HOLD_W-1:0] key_hold_nxt [KEYS_N];
  logic [KEYS_N-1:0] hit;
  logic              is_key;
  logic              is_tick;
  logic              is_cmd;

  assign is_key  = (kind_r == KIND_KEY);
  assign is_tick = (kind_r == KIND_TICK);
  assign is_cmd  = (kind_r == KIND_CMD);

  always_comb begin
    for (int i = 0; i < KEYS_N; i++) begin
      key_hold_nxt[i] = key_hold_r[i];
      hit[i]          = 1'b0;
      if (fire && is_key) begin
        if (!levels_r[i]) begin
          if (key_hold_r[i] != HOLD_MAX) begin
            key_hold_nxt[i] = key_hold_r[i] + HOLD_W'(1);
            hit[i] = (press_r != '0) && (key_hold_nxt[i] == press_r);
          end
        end else begin
          key_hold_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEYS_N; i++) begin
        key_hold_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < KEYS_N; i++) begin
        key_hold_r[i] <= key_hold_nxt[i];
      end
    end
  end

  // Control bundles for the two channels.
  dcmc_ctl_t          ctl [2];
  logic [STATE_W-1:0] applied_nxt [2];
  logic [1:0]         open_nxt;
  logic [1:0]         changed;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      ctl[c].fire      = fire;
      ctl[c].is_key    = is_key;
      ctl[c].is_tick   = is_tick;
      ctl[c].is_cmd    = is_cmd;
      ctl[c].up_hit    = hit[c];
      ctl[c].dn_hit    = hit[c+2];
      ctl[c].cmd_hit   = (chan_r == 1'(c)) && (cmd_r != CMD_BAD);
      ctl[c].cmd_state = cmd_r;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_chan
    dcmc_channel u_chan (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl[c]),
      .run_limit   (run_limit_r),
      .applied_nxt (applied_nxt[c]),
      .open_nxt    (open_nxt[c]),
      .changed     (changed[c])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_relay_bits <= {applied_nxt[1] == ST_DOWN, applied_nxt[1] == ST_UP,
                         applied_nxt[0] == ST_DOWN, applied_nxt[0] == ST_UP};
      out_led_up_ch0   <= (applied_nxt[0] == ST_UP)   ? led_bright_r : led_dim_r;
      out_led_up_ch1   <= (applied_nxt[1] == ST_UP)   ? led_bright_r : led_dim_r;
      out_led_down_ch0 <= (applied_nxt[0] == ST_DOWN) ? led_bright_r : led_dim_r;
      out_led_down_ch1 <= (applied_nxt[1] == ST_DOWN) ? led_bright_r : led_dim_r;
      out_open_flags    <= open_nxt;
      out_state_changed <= is_tick && (changed != 2'b00);
    end
  end

endmodule

// ===== hdl/dcmc_channel.sv =====
// ---------------------------------------------------------------------------
// Dual cover motor controller: one motor channel
// Holds the requested and applied state, run tick counter and open flag.
// ---------------------------------------------------------------------------
module dcmc_channel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcmc_pkg::dcmc_ctl_t           ctl,
  input  logic [dcmc_pkg::TICK_W-1:0]   run_limit,
  output logic [dcmc_pkg::STATE_W-1:0]  applied_nxt,
  output logic                          open_nxt,
  output logic                          changed
);
  import dcmc_pkg::*;

  logic [STATE_W-1:0] req_r, req_nxt;
  logic [STATE_W-1:0] app_r, app_nxt;
  logic [TICK_W-1:0]  run_r, run_nxt;
  logic               open_r, open_nxt_l;
  logic [TICK_W-1:0]  run_inc;

  assign run_inc = run_r + TICK_W'(1);

  // Next-state logic for one item.
  always_comb begin
    req_nxt    = req_r;
    app_nxt    = app_r;
    run_nxt    = run_r;
    open_nxt_l = open_r;
    changed    = 1'b0;
    if (ctl.fire) begin
      if (ctl.is_key) begin
        // Up wins over down; a press from stop starts its direction, else it stops.
        if (ctl.up_hit) begin
          req_nxt = (req_r == ST_STOP) ? ST_UP : ST_STOP;
        end else if (ctl.dn_hit) begin
          req_nxt = (req_r == ST_STOP) ? ST_DOWN : ST_STOP;
        end
      end else if (ctl.is_tick) begin
        // Apply the pending request.
        if (app_r != req_r) begin
          app_nxt = req_r;
          changed = 1'b1;
          if (req_r == ST_UP) begin
            open_nxt_l = 1'b1;
          end else if (req_r == ST_DOWN) begin
            open_nxt_l = 1'b0;
          end
        end
        // Count running ticks and force stop at the limit.
        if (req_r != ST_STOP) begin
          run_nxt = run_inc;
          if (run_inc == run_limit) begin
            req_nxt = ST_STOP;
          end
        end else begin
          run_nxt = '0;
        end
      end else if (ctl.is_cmd && ctl.cmd_hit) begin
        req_nxt = ctl.cmd_state;
      end
    end
  end

  assign applied_nxt = app_nxt;
  assign open_nxt    = open_nxt_l;

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= ST_STOP;
      app_r  <= ST_STOP;
      run_r  <= '0;
      open_r <= 1'b1;
    end else begin
      req_r  <= req_nxt;
      app_r  <= app_nxt;
      run_r  <= run_nxt;
      open_r <= open_nxt_l;
    end
  end

endmodule

// ===== hdl/dcmc_checker.sv =====
// ---------------------------------------------------------------------------
// Dual cover motor controller checker
// Port-level assertions on relay, open flag and result channel behavior.
// ---------------------------------------------------------------------------
module dcmc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [3:0]                   out_relay_bits,
  input logic [1:0]                   out_open_flags,
  input logic                         out_state_changed
);
  import dcmc_pkg::*;

  // A motor never drives both directions at once.
  a_relay_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_relay_bits[0] && out_relay_bits[1]) &&
                  !(out_relay_bits[2] && out_relay_bits[3]))
    else $error("both relays of a channel are on");

  // A motor running up marks its cover open, running down marks it closed.
  a_open_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_relay_bits[0] || out_open_flags[0]) &&
                  (!out_relay_bits[1] || !out_open_flags[0]) &&
                  (!out_relay_bits[2] || out_open_flags[1]) &&
                  (!out_relay_bits[3] || !out_open_flags[1]))
    else $error("open flag disagrees with running direction");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relay_bits) &&
                                $stable(out_open_flags) && $stable(out_state_changed))
    else $error("stalled result item changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dual_cover_motor_controller dcmc_checker u_dcmc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_relay_bits    (out_relay_bits),
  .out_open_flags    (out_open_flags),
  .out_state_changed (out_state_changed)
);
